// ===== rtl/tpsd_pkg.sv =====
// Shared types, constants and register codes of the temporal pixel stability detector.
package tpsd_pkg;

   localparam int MAX_HISTORY      = 8;
   localparam int MAX_FRAME_PIXELS = 4096;

   localparam int CHAN_W   = 8;
   localparam int CHANNELS = 3;
   localparam int PIXEL_W  = CHANNELS * CHAN_W;
   localparam int POS_W    = 12;

   localparam int DEPTH_W  = 4;
   localparam int TOL_W    = 8;
   localparam int CHCNT_W  = 2;
   localparam int FPIX_W   = 13;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_HISTORY_DEPTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PIXELS  = 2'd3;

   localparam logic [DEPTH_W-1:0] HISTORY_DEPTH_RESET = 4'd5;
   localparam logic [TOL_W-1:0]   TOLERANCE_RESET     = 8'd5;
   localparam logic [CHCNT_W-1:0] CHANNEL_COUNT_RESET = 2'd3;
   localparam logic [FPIX_W-1:0]  FRAME_PIXELS_RESET  = 13'd4096;

   typedef struct packed {
      logic [CHAN_W-1:0] chan0;
      logic [CHAN_W-1:0] chan1;
      logic [CHAN_W-1:0] chan2;
   } req_type;

   typedef struct packed {
      logic             stable;
      logic [POS_W-1:0] pixel_position;
      logic             frame_last;
   } rsp_type;

   // Position tag that travels with a pixel through the compare stage.
   typedef struct packed {
      logic [POS_W-1:0] pixel_position;
      logic             frame_last;
   } tag_type;

   // Compare settings seen by every lane.
   typedef struct packed {
      logic [TOL_W-1:0]   tolerance;
      logic [CHCNT_W-1:0] channel_count;
   } cmp_cfg_type;

endpackage

// ===== rtl/tpsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tpsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tpsd_lane.sv =====
// One history slot: its frame memory and the per-channel tolerance compare.
module tpsd_lane #(
   parameter int MAX_FRAME_PIXELS = tpsd_pkg::MAX_FRAME_PIXELS
) (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic                                wr_en,
   input  logic [$clog2(MAX_FRAME_PIXELS)-1:0] addr,
   input  logic [tpsd_pkg::PIXEL_W-1:0]        wr_pixel,
   input  logic [tpsd_pkg::PIXEL_W-1:0]        cmp_pixel,
   input  logic                                check,
   input  tpsd_pkg::cmp_cfg_type               cfg,
   output logic                                ok
);

   logic [tpsd_pkg::PIXEL_W-1:0] old_pixel;

   tpsd_ram #(
      .WIDTH (tpsd_pkg::PIXEL_W),
      .DEPTH (MAX_FRAME_PIXELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_pixel),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (old_pixel)
   );

   // Fail when any active channel is further than tolerance from the stored frame.
   always_comb begin
      logic [tpsd_pkg::CHAN_W-1:0] cur;
      logic [tpsd_pkg::CHAN_W-1:0] old;
      logic [tpsd_pkg::CHAN_W-1:0] diff;
      ok = 1'b1;
      for (int c = 0; c < tpsd_pkg::CHANNELS; c++) begin
         cur  = cmp_pixel[c*tpsd_pkg::CHAN_W +: tpsd_pkg::CHAN_W];
         old  = old_pixel[c*tpsd_pkg::CHAN_W +: tpsd_pkg::CHAN_W];
         diff = (cur > old) ? cur - old : old - cur;
         if (check && (c < int'(cfg.channel_count)) && (diff > cfg.tolerance)) begin
            ok = 1'b0;
         end
      end
   end

endmodule

// ===== rtl/tpsd_merge.sv =====
// Combine lane verdicts into the stable flag and hold the result register.
module tpsd_merge #(
   parameter int MAX_HISTORY = tpsd_pkg::MAX_HISTORY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [MAX_HISTORY-1:0] lane_ok,
   input  tpsd_pkg::tag_type      in_tag,
   output logic                   advance,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tpsd_pkg::rsp_type      rsp_data
);

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   tpsd_pkg::rsp_type rsp_data_ff;

   // Move forward when the result register is empty or being taken.
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = advance ? in_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && in_valid) begin
         rsp_data_ff.stable         <= &lane_ok;
         rsp_data_ff.pixel_position <= in_tag.pixel_position;
         rsp_data_ff.frame_last     <= in_tag.frame_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/temporal_pixel_stability_detector.sv =====
// Top level of the temporal pixel stability detector.
//
// Takes one downscaled pixel per clock in raster order while req_stall is
// low and returns one transaction per pixel: a stable flag, the raster
// position and a mark on the last pixel of a frame. Each of the
// MAX_HISTORY history slots is a lane with its own MAX_FRAME_PIXELS x
// 24-bit memory; on acceptance the pixel is written into the newest slot
// while every slot is read at the same position, the lanes compare in the
// next cycle and a merge stage ANDs their verdicts into the result
// register. Throughput is one pixel per clock while rsp_stall is low,
// limited by the single read and write port of each lane memory. From the
// compare stage registers a pixel moves into the result register, which
// loads when it is empty or being taken. Input keeps flowing while a
// result waits, until the compare stage is full too. History memories are
// not cleared after reset: a slot is compared only after the current frame
// geometry has filled it, so no clearing pass is needed and the block takes
// pixels from the first cycle after reset. Writing frame_pixels restarts the
// frame and drops all stored frames from comparison.
module temporal_pixel_stability_detector #(
   parameter int MAX_HISTORY      = tpsd_pkg::MAX_HISTORY,
   parameter int MAX_FRAME_PIXELS = tpsd_pkg::MAX_FRAME_PIXELS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tpsd_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tpsd_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [tpsd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tpsd_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int PosW   = $clog2(MAX_FRAME_PIXELS);
   localparam int NpW    = PosW + 1;
   localparam int SlotW  = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
   localparam int AgeW   = SlotW + 1;
   localparam int HeldW  = $clog2(MAX_HISTORY + 2);
   localparam int CmpW   = AgeW + HeldW;

   // Configuration registers.
   logic [tpsd_pkg::DEPTH_W-1:0] history_depth_ff, history_depth_in;
   logic [tpsd_pkg::TOL_W-1:0]   tolerance_ff, tolerance_in;
   logic [tpsd_pkg::CHCNT_W-1:0] channel_count_ff, channel_count_in;
   logic [tpsd_pkg::FPIX_W-1:0]  frame_pixels_ff, frame_pixels_in;

   // Scan state.
   logic [PosW-1:0]  scan_ff, scan_in;
   logic [HeldW-1:0] held_ff, held_in;
   logic [SlotW-1:0] newest_ff, newest_in;

   // Compare stage: pixel and tag wait here for the lane memories.
   logic                         s1_valid_ff, s1_valid_in;
   logic [tpsd_pkg::PIXEL_W-1:0] s1_pixel_ff;
   tpsd_pkg::tag_type            s1_tag_ff;
   logic [MAX_HISTORY-1:0]       s1_mask_ff;

   // Decoded settings and values of the pixel being accepted.
   logic [NpW-1:0]               npix;
   logic [HeldW-1:0]             depth_eff;
   tpsd_pkg::cmp_cfg_type        cmp_cfg;
   logic                         accept;
   logic                         advance;
   logic [PosW-1:0]              pos_cur;
   logic [NpW-1:0]               pos_inc;
   logic                         last_cur;
   logic [HeldW-1:0]             held_pre;
   logic [HeldW-1:0]             held_cur;
   logic [SlotW-1:0]             newest_cur;
   logic [MAX_HISTORY-1:0]       mask_cur;
   logic [31:0]                  pos_wide;
   logic [tpsd_pkg::PIXEL_W-1:0] pixel_cur;
   logic [MAX_HISTORY-1:0]       lane_ok;
   tpsd_pkg::tag_type            tag_cur;

   // Clamp out-of-range settings to what the design can hold.
   always_comb begin
      if (frame_pixels_ff == '0) begin
         npix = NpW'(1);
      end else if (32'(frame_pixels_ff) > 32'(MAX_FRAME_PIXELS)) begin
         npix = NpW'(MAX_FRAME_PIXELS);
      end else begin
         npix = NpW'(frame_pixels_ff);
      end
      if (history_depth_ff == '0) begin
         depth_eff = HeldW'(1);
      end else if (32'(history_depth_ff) > 32'(MAX_HISTORY)) begin
         depth_eff = HeldW'(MAX_HISTORY);
      end else begin
         depth_eff = HeldW'(history_depth_ff);
      end
      cmp_cfg.tolerance     = tolerance_ff;
      cmp_cfg.channel_count = (channel_count_ff == '0) ? tpsd_pkg::CHCNT_W'(1)
                                                       : channel_count_ff;
   end

   // Take a new pixel when the compare stage is empty or moving on.
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign pixel_cur = {req_data.chan2, req_data.chan1, req_data.chan0};

   // Position, slot and fill level that apply to the pixel being accepted.
   always_comb begin
      pos_cur  = (NpW'(scan_ff) >= npix) ? '0 : scan_ff;
      pos_inc  = NpW'(pos_cur) + NpW'(1);
      last_cur = (pos_inc == npix);
      pos_wide = 32'(pos_cur);
      if (pos_cur == '0) begin
         held_pre = held_ff + HeldW'(1);
      end else begin
         held_pre = held_ff;
      end
      held_cur = (held_pre > depth_eff) ? depth_eff : held_pre;
      // Open a new slot at the start of every frame except the first one after reset or a frame_pixels write.
      if ((pos_cur == '0) && (held_ff != '0)) begin
         newest_cur = (newest_ff == SlotW'(MAX_HISTORY - 1)) ? '0 : newest_ff + SlotW'(1);
      end else begin
         newest_cur = newest_ff;
      end
      tag_cur.pixel_position = pos_wide[tpsd_pkg::POS_W-1:0];
      tag_cur.frame_last     = last_cur;
   end

   // Select the older frames to compare: slot age 1 up to held_cur - 1.
   always_comb begin
      logic [AgeW-1:0] age;
      for (int j = 0; j < MAX_HISTORY; j++) begin
         if ({1'b0, newest_cur} >= AgeW'(j)) begin
            age = {1'b0, newest_cur} - AgeW'(j);
         end else begin
            age = {1'b0, newest_cur} + AgeW'(MAX_HISTORY - j);
         end
         mask_cur[j] = (age != '0) && (CmpW'(age) < CmpW'(held_cur));
      end
   end

   // Next state of configuration and scan registers.
   always_comb begin
      history_depth_in = history_depth_ff;
      tolerance_in     = tolerance_ff;
      channel_count_in = channel_count_ff;
      frame_pixels_in  = frame_pixels_ff;
      scan_in          = scan_ff;
      held_in          = held_ff;
      newest_in        = newest_ff;
      if (accept) begin
         scan_in   = last_cur ? '0 : pos_inc[PosW-1:0];
         held_in   = held_cur;
         newest_in = newest_cur;
      end
      if (csr_wr_en) begin
         unique case (csr_index)
            tpsd_pkg::CSR_HISTORY_DEPTH: begin
               history_depth_in = csr_wr_data[tpsd_pkg::DEPTH_W-1:0];
            end
            tpsd_pkg::CSR_TOLERANCE: begin
               tolerance_in = csr_wr_data[tpsd_pkg::TOL_W-1:0];
            end
            tpsd_pkg::CSR_CHANNEL_COUNT: begin
               channel_count_in = csr_wr_data[tpsd_pkg::CHCNT_W-1:0];
            end
            tpsd_pkg::CSR_FRAME_PIXELS: begin
               // Restart the frame and drop stored frames of the old geometry.
               frame_pixels_in = csr_wr_data[tpsd_pkg::FPIX_W-1:0];
               scan_in         = '0;
               held_in         = '0;
            end
         endcase
      end
   end

   // Hold the compare stage until the merge stage takes it.
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_depth_ff <= tpsd_pkg::HISTORY_DEPTH_RESET;
         tolerance_ff     <= tpsd_pkg::TOLERANCE_RESET;
         channel_count_ff <= tpsd_pkg::CHANNEL_COUNT_RESET;
         frame_pixels_ff  <= tpsd_pkg::FRAME_PIXELS_RESET;
         scan_ff          <= '0;
         held_ff          <= '0;
         newest_ff        <= '0;
         s1_valid_ff      <= 1'b0;
      end else begin
         history_depth_ff <= history_depth_in;
         tolerance_ff     <= tolerance_in;
         channel_count_ff <= channel_count_in;
         frame_pixels_ff  <= frame_pixels_in;
         scan_ff          <= scan_in;
         held_ff          <= held_in;
         newest_ff        <= newest_in;
         s1_valid_ff      <= s1_valid_in;
      end
      if (accept) begin
         s1_pixel_ff <= pixel_cur;
         s1_tag_ff   <= tag_cur;
         s1_mask_ff  <= mask_cur;
      end
   end

   // One lane per history slot: write the newest, read all at the same position.
   for (genvar j = 0; j < MAX_HISTORY; j++) begin : g_lane
      tpsd_lane #(
         .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
      ) u_lane (
         .clock     (clock),
         .rd_en     (accept),
         .wr_en     (accept && (newest_cur == SlotW'(j))),
         .addr      (pos_cur),
         .wr_pixel  (pixel_cur),
         .cmp_pixel (s1_pixel_ff),
         .check     (s1_mask_ff[j]),
         .cfg       (cmp_cfg),
         .ok        (lane_ok[j])
      );
   end

   tpsd_merge #(
      .MAX_HISTORY (MAX_HISTORY)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .lane_ok   (lane_ok),
      .in_tag    (s1_tag_ff),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_scan_in_frame: assert property (@(posedge clock) disable iff (reset)
      NpW'(scan_ff) < npix)
      else $error("scan position outside the frame");

   a_mask_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> ($countones(s1_mask_ff) == (int'($past(held_cur)) - 1)))
      else $error("compared slot count differs from stored frame count");

   a_wrap_on_last: assert property (@(posedge clock) disable iff (reset)
      (accept && last_cur) |=> (scan_ff == '0))
      else $error("scan position did not wrap after last pixel");

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty compare stage");
`endif

endmodule

// ===== test/temporal_pixel_stability_detector_tb.sv =====
// Self-checking testbench of the temporal pixel stability detector.
module temporal_pixel_stability_detector_tb;

   // One downscaled pixel with its channels indexed 0..2.
   typedef logic [tpsd_pkg::CHANNELS-1:0][tpsd_pkg::CHAN_W-1:0] pixel_chans_type;

   localparam int SETTLE_CYCLES  = 4;     // idle margin after the last result before a register write
   localparam int DRAIN_CYCLES   = 10;    // extra cycles after the last result
   localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction at all
   localparam int HOLD_AT        = 300;   // result count that starts the long receiver hold
   localparam int HOLD_CYCLES    = 120;
   localparam int QUIET_FROM     = 400;   // stretch with no random idling on either side
   localparam int QUIET_TO       = 600;
   localparam int FOLD_ITEMS     = 120;
   localparam int MID_FRAME      = 160;
   localparam int MID_ITEMS      = 3 * MID_FRAME + 20;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_ITEMS    = 125;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   tpsd_pkg::req_type                req_data = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   tpsd_pkg::rsp_type                rsp_data;
   logic                             csr_wr_en = 1'b0;
   logic [tpsd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tpsd_pkg::CSR_DATA_W-1:0]  csr_wr_data = '0;

   temporal_pixel_stability_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow of the block: register copies and per-pixel frame history.
   // ---------------------------------------------------------------------
   logic [tpsd_pkg::DEPTH_W-1:0] depth_reg = tpsd_pkg::HISTORY_DEPTH_RESET;
   logic [tpsd_pkg::TOL_W-1:0]   tol_reg   = tpsd_pkg::TOLERANCE_RESET;
   logic [tpsd_pkg::CHCNT_W-1:0] chcnt_reg = tpsd_pkg::CHANNEL_COUNT_RESET;
   logic [tpsd_pkg::FPIX_W-1:0]  fpix_reg  = tpsd_pkg::FRAME_PIXELS_RESET;

   pixel_chans_type stored_frames [tpsd_pkg::MAX_HISTORY][tpsd_pkg::MAX_FRAME_PIXELS];
   int unsigned     frames_kept   = 0;
   int unsigned     next_position = 0;
   int unsigned     newest_frame  = 0;

   // Stimulus side: a reference scene that pixels jitter around.
   pixel_chans_type scene [tpsd_pkg::MAX_FRAME_PIXELS];
   int unsigned     gen_pos = 0;

   tpsd_pkg::req_type pending_pixels [$];
   tpsd_pkg::rsp_type expected_results [$];

   int pixels_sent  = 0;
   int results_seen = 0;
   int reg_writes   = 0;
   int error_count  = 0;

   // Out-of-range register values fold back into the legal range.
   function automatic int unsigned depth_in_use();
      if (depth_reg == 0) return 1;
      if (depth_reg > tpsd_pkg::MAX_HISTORY) return tpsd_pkg::MAX_HISTORY;
      return depth_reg;
   endfunction

   function automatic int unsigned pixels_in_use();
      if (fpix_reg == 0) return 1;
      if (fpix_reg > tpsd_pkg::MAX_FRAME_PIXELS) return tpsd_pkg::MAX_FRAME_PIXELS;
      return fpix_reg;
   endfunction

   function automatic int unsigned channels_in_use();
      return (chcnt_reg == 0) ? 1 : chcnt_reg;
   endfunction

   // Store the pixel as part of the current frame and judge it against
   // every older frame still held for its position.
   function automatic tpsd_pkg::rsp_type track_pixel(tpsd_pkg::req_type px);
      int unsigned       pos, depth, npix, nch, a, b;
      pixel_chans_type   cur, prior;
      logic              steady;
      tpsd_pkg::rsp_type r;
      depth = depth_in_use();
      npix  = pixels_in_use();
      nch   = channels_in_use();
      if (next_position >= npix) next_position = 0;
      pos = next_position;
      // First pixel of a frame: open a new slot unless history is empty.
      if (pos == 0) begin
         if (frames_kept > 0) newest_frame = (newest_frame + 1) % tpsd_pkg::MAX_HISTORY;
         frames_kept++;
      end
      // A lowered depth takes effect at once.
      if (frames_kept > depth) frames_kept = depth;
      cur = {px.chan2, px.chan1, px.chan0};
      stored_frames[newest_frame][pos] = cur;
      steady = 1'b1;
      for (int k = 1; k < frames_kept; k++) begin
         prior = stored_frames[(newest_frame + tpsd_pkg::MAX_HISTORY - k) %
                               tpsd_pkg::MAX_HISTORY][pos];
         for (int c = 0; c < nch; c++) begin
            a = cur[c];
            b = prior[c];
            if ((a > b ? a - b : b - a) > tol_reg) steady = 1'b0;
         end
      end
      r.stable         = steady;
      r.pixel_position = tpsd_pkg::POS_W'(pos);
      r.frame_last     = (pos == npix - 1);
      next_position    = (pos + 1 >= npix) ? 0 : pos + 1;
      return r;
   endfunction

   function automatic tpsd_pkg::req_type pixel(input int c0, input int c1, input int c2);
      return '{chan0: tpsd_pkg::CHAN_W'(c0), chan1: tpsd_pkg::CHAN_W'(c1),
               chan2: tpsd_pkg::CHAN_W'(c2)};
   endfunction

   // Mostly small jitter around the scene, sometimes a moved pixel or pure
   // noise; channels that are not compared get random values half the time.
   function automatic tpsd_pkg::req_type make_pixel();
      pixel_chans_type base, val;
      int              amp, v, pick;
      pick = $urandom_range(99);
      if (pick < 8) scene[gen_pos] = pixel_chans_type'($urandom);
      base = scene[gen_pos];
      amp  = ($urandom_range(3) == 0) ? int'(tol_reg) + 1 : int'(tol_reg) / 2;
      for (int c = 0; c < tpsd_pkg::CHANNELS; c++) begin
         if (pick >= 92 || (c >= channels_in_use() && $urandom_range(1) == 1)) begin
            val[c] = tpsd_pkg::CHAN_W'($urandom);
         end else begin
            v = int'(base[c]) + int'($urandom_range(2 * amp)) - amp;
            val[c] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : tpsd_pkg::CHAN_W'(v);
         end
      end
      return pixel(val[0], val[1], val[2]);
   endfunction

   // Queue one pixel and keep the scene position in step with the block.
   task automatic push_pixel(input tpsd_pkg::req_type px);
      int unsigned npix;
      npix = pixels_in_use();
      pending_pixels.insert(pending_pixels.size(), px);
      gen_pos = (gen_pos + 1 >= npix) ? 0 : gen_pos + 1;
   endtask

   task automatic push_random(input int count);
      repeat (count) push_pixel(make_pixel());
   endtask

   // Hold until every queued pixel went in and every result came back.
   task automatic wait_idle();
      while (pending_pixels.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register while idle and mirror it in the shadow copy.
   task automatic write_reg(input logic [tpsd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [tpsd_pkg::CSR_DATA_W-1:0]  value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      reg_writes++;
      case (idx)
         tpsd_pkg::CSR_HISTORY_DEPTH: depth_reg = value[tpsd_pkg::DEPTH_W-1:0];
         tpsd_pkg::CSR_TOLERANCE:     tol_reg   = value[tpsd_pkg::TOL_W-1:0];
         tpsd_pkg::CSR_CHANNEL_COUNT: chcnt_reg = value[tpsd_pkg::CHCNT_W-1:0];
         tpsd_pkg::CSR_FRAME_PIXELS: begin
            // New geometry: restart the frame and forget stored frames.
            fpix_reg      = value[tpsd_pkg::FPIX_W-1:0];
            next_position = 0;
            frames_kept   = 0;
            gen_pos       = 0;
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Driver: offer queued pixels, predict each accepted transaction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.insert(expected_results.size(), track_pixel(req_data));
            pixels_sent++;
         end
         // Advance only when the current pixel is gone; a stalled one holds.
         if (!req_valid || !req_stall) begin
            if (pending_pixels.size() != 0 &&
                !((pixels_sent < QUIET_FROM || pixels_sent >= QUIET_TO) &&
                  $urandom_range(99) < 15)) begin
               req_data  <= pending_pixels[0];
               pending_pixels.delete(0);
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each result transaction against the oldest prediction.
   // ---------------------------------------------------------------------
   int                hold_left = 0;
   bit                hold_done = 1'b0;
   tpsd_pkg::rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("result at position %0d with no pixel pending", rsp_data.pixel_position);
               error_count++;
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (rsp_data.stable !== want.stable) begin
                  $error("stable: expected %0d, got %0d (position %0d)",
                         want.stable, rsp_data.stable, want.pixel_position);
                  error_count++;
               end
               if (rsp_data.pixel_position !== want.pixel_position) begin
                  $error("pixel_position: expected %0d, got %0d",
                         want.pixel_position, rsp_data.pixel_position);
                  error_count++;
               end
               if (rsp_data.frame_last !== want.frame_last) begin
                  $error("frame_last: expected %0d, got %0d (position %0d)",
                         want.frame_last, rsp_data.frame_last, want.pixel_position);
                  error_count++;
               end
            end
         end
         // Long hold-off once: the sender keeps offering so the block backs up.
         if (!hold_done && results_seen == HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 15);
         end
      end
   end

   // Watchdog: stop a run that makes no progress.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus sequence.
   // ---------------------------------------------------------------------
   initial begin
      for (int i = 0; i < tpsd_pkg::MAX_FRAME_PIXELS; i++) begin
         scene[i] = pixel_chans_type'($urandom);
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Power-up settings: first pixels of a fresh frame, nothing to compare.
      push_pixel(pixel(0, 0, 0));
      push_pixel(pixel(255, 255, 255));
      push_pixel(pixel(8'h5a, 8'ha5, 8'h3c));
      wait_idle();

      // One-pixel frames, full depth, zero tolerance: any change is unstable.
      write_reg(tpsd_pkg::CSR_FRAME_PIXELS, 13'd1);
      write_reg(tpsd_pkg::CSR_HISTORY_DEPTH, 13'd8);
      write_reg(tpsd_pkg::CSR_TOLERANCE, 13'd0);
      push_pixel(pixel(0, 0, 0));
      push_pixel(pixel(0, 0, 0));
      push_pixel(pixel(255, 255, 255));
      push_pixel(pixel(255, 255, 255));
      wait_idle();

      // Widest tolerance accepts a full-scale difference.
      write_reg(tpsd_pkg::CSR_TOLERANCE, 13'd255);
      push_pixel(pixel(0, 0, 0));
      wait_idle();

      // Channel count zero compares channel 0 only.
      write_reg(tpsd_pkg::CSR_TOLERANCE, 13'd0);
      write_reg(tpsd_pkg::CSR_HISTORY_DEPTH, 13'd2);
      write_reg(tpsd_pkg::CSR_CHANNEL_COUNT, 13'd0);
      push_pixel(pixel(0, 1, 2));
      push_pixel(pixel(0, 200, 17));
      wait_idle();

      // Two channels: channel 2 ignored, channel 1 compared.
      write_reg(tpsd_pkg::CSR_CHANNEL_COUNT, 13'd2);
      push_pixel(pixel(0, 200, 99));
      push_pixel(pixel(0, 201, 99));
      wait_idle();

      write_reg(tpsd_pkg::CSR_CHANNEL_COUNT, 13'd1);
      push_pixel(pixel(0, 55, 66));
      wait_idle();

      // Depth zero acts as one: only the current frame, always stable.
      write_reg(tpsd_pkg::CSR_HISTORY_DEPTH, 13'd0);
      push_pixel(pixel(7, 7, 7));
      push_pixel(pixel(200, 3, 9));
      wait_idle();

      // Depth above the maximum and frame size zero both fold back.
      write_reg(tpsd_pkg::CSR_HISTORY_DEPTH, 13'd15);
      write_reg(tpsd_pkg::CSR_FRAME_PIXELS, 13'd0);
      write_reg(tpsd_pkg::CSR_CHANNEL_COUNT, 13'd3);
      push_pixel(pixel(200, 3, 9));
      push_pixel(pixel(201, 3, 9));
      wait_idle();

      // Three-pixel frames: frame_last on the third, tolerance edge.
      write_reg(tpsd_pkg::CSR_FRAME_PIXELS, 13'd3);
      write_reg(tpsd_pkg::CSR_HISTORY_DEPTH, 13'd2);
      write_reg(tpsd_pkg::CSR_TOLERANCE, 13'd3);
      push_pixel(pixel(10, 20, 30));
      push_pixel(pixel(10, 20, 30));
      push_pixel(pixel(10, 20, 30));
      push_pixel(pixel(13, 20, 30));
      push_pixel(pixel(14, 20, 30));
      push_pixel(pixel(10, 20, 30));
      wait_idle();

      // Frame size from the top of the field folds to the largest frame.
      write_reg(tpsd_pkg::CSR_FRAME_PIXELS, 13'h1fff);
      push_random(FOLD_ITEMS);
      wait_idle();

      // Mid-size frames over several frames; the long receiver hold and the
      // no-idle stretch fall in this phase.
      write_reg(tpsd_pkg::CSR_FRAME_PIXELS, tpsd_pkg::FPIX_W'(MID_FRAME));
      write_reg(tpsd_pkg::CSR_HISTORY_DEPTH, 13'd4);
      write_reg(tpsd_pkg::CSR_TOLERANCE, 13'd8);
      push_random(MID_ITEMS);
      wait_idle();

      // Random settings over small frames; history often survives a phase.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0 || $urandom_range(2) == 0) begin
            case ($urandom_range(5))
               0:       write_reg(tpsd_pkg::CSR_FRAME_PIXELS, 13'd0);
               1:       write_reg(tpsd_pkg::CSR_FRAME_PIXELS,
                                  tpsd_pkg::FPIX_W'($urandom_range(17, 64)));
               default: write_reg(tpsd_pkg::CSR_FRAME_PIXELS,
                                  tpsd_pkg::FPIX_W'($urandom_range(1, 16)));
            endcase
         end
         // Unused upper data bits are random and must be ignored.
         case ($urandom_range(5))
            0:       write_reg(tpsd_pkg::CSR_HISTORY_DEPTH, {9'($urandom), 4'd0});
            1:       write_reg(tpsd_pkg::CSR_HISTORY_DEPTH, {9'($urandom), 4'd15});
            2:       write_reg(tpsd_pkg::CSR_HISTORY_DEPTH, {9'($urandom), 4'd8});
            3:       write_reg(tpsd_pkg::CSR_HISTORY_DEPTH, {9'($urandom), 4'd1});
            default: write_reg(tpsd_pkg::CSR_HISTORY_DEPTH,
                               {9'($urandom), 4'($urandom_range(2, 7))});
         endcase
         case ($urandom_range(3))
            0:       write_reg(tpsd_pkg::CSR_TOLERANCE, {5'($urandom), 8'd0});
            1:       write_reg(tpsd_pkg::CSR_TOLERANCE, {5'($urandom), 8'd255});
            2:       write_reg(tpsd_pkg::CSR_TOLERANCE,
                               {5'($urandom), 8'($urandom_range(1, 20))});
            default: write_reg(tpsd_pkg::CSR_TOLERANCE,
                               {5'($urandom), 8'($urandom_range(21, 254))});
         endcase
         write_reg(tpsd_pkg::CSR_CHANNEL_COUNT, {11'($urandom), 2'($urandom_range(3))});
         push_random(PHASE_ITEMS);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         error_count++;
      end

      $display("covered %0d pixels, %0d results, %0d register writes",
               pixels_sent, results_seen, reg_writes);
      $display("frame sizes 1 to 64, 160 and folded 4096, depths 0 to 15, tolerance 0 to 255");
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tpsd_pkg.sv
rtl/tpsd_ram.sv
rtl/tpsd_lane.sv
rtl/tpsd_merge.sv
rtl/temporal_pixel_stability_detector.sv
test/temporal_pixel_stability_detector_tb.sv
